// ===== hw/rtl/single_wire_byte_transceiver_macros.svh =====
// assertion helpers for the single wire byte transceiver
`ifndef SINGLE_WIRE_BYTE_TRANSCEIVER_MACROS_SVH
`define SINGLE_WIRE_BYTE_TRANSCEIVER_MACROS_SVH

`ifndef ASSERT_OFF
`define SWBT_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("swbt assertion failed");
`define SWBT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("swbt assertion failed");
`else
`define SWBT_ASSERT_RST(label, clk, rst, prop)
`define SWBT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/swbt_pkg.sv =====
package swbt_pkg;

   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_FALL  = 3'd1;
   localparam logic [2:0] ACT_SEND  = 3'd2;
   localparam logic [2:0] ACT_POP   = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   localparam logic [4:0] LAST_SAMPLE = 5'd17;
   localparam logic [4:0] FRAME_END   = 5'd18;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_FALL,
      OP_SEND,
      OP_POP,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [2:0] action;
      logic       line_in;
      logic [7:0] send_byte;
   } req_type;

   typedef struct packed {
      logic       line_out;
      logic [7:0] popped_byte;
      logic       pop_valid;
      logic [3:0] queue_count;
      logic       busy_res;
      logic       send_accepted;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic       line_in;
      logic [7:0] send_byte;
   } cmd_type;

   function automatic op_type decode_action(input logic [2:0] action);
      op_type op;
      case (action)
         ACT_TICK:  op = OP_TICK;
         ACT_FALL:  op = OP_FALL;
         ACT_SEND:  op = OP_SEND;
         ACT_POP:   op = OP_POP;
         ACT_CLEAR: op = OP_CLEAR;
         default:   op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

// ===== hw/rtl/swbt_front.sv =====
module swbt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swbt_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output swbt_pkg::cmd_type cmd_data
);

   swbt_pkg::cmd_type q_ff [2];
   logic              wp_ff, wp_in;
   logic              rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;
   swbt_pkg::cmd_type cmd_new;

   assign req_stall = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rp_ff];

   assign push = req_valid && !req_stall;
   assign pop  = cmd_valid && cmd_take;

   always_comb begin
      cmd_new.op        = swbt_pkg::decode_action(req_data.action);
      cmd_new.line_in   = req_data.line_in;
      cmd_new.send_byte = req_data.send_byte;
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

endmodule

// ===== hw/rtl/swbt_back.sv =====
`include "single_wire_byte_transceiver_macros.svh"

module swbt_back #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  swbt_pkg::cmd_type cmd_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swbt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      LINK_IDLE,
      LINK_RECV,
      LINK_SEND
   } link_type;

   link_type   mode_ff, mode_in;
   logic [4:0] cnt_ff, cnt_in, cnt_nx;
   logic [7:0] tx_ff, tx_in;
   logic [7:0] rx_ff, rx_in;
   logic       drive_ff, drive_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] rd_nx, wr_nx;
   logic [IDX_W:0]   held;
   logic [7:0] null_ff;

   logic [7:0] mem [FIFO_DEPTH];
   logic [7:0] rd_data_ff;
   logic       mem_we;

   logic              s1_valid_ff;
   swbt_pkg::rsp_type s1_ff, s1_in;
   logic              s1_mem_ff, s1_mem_in;
   logic              s1_adv, s1_load, work;
   swbt_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   assign s1_adv   = !rsp_valid_ff || !rsp_stall;
   assign s1_load  = !s1_valid_ff || s1_adv;
   assign cmd_take = s1_load;
   assign work     = cmd_valid && s1_load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rd_nx = (rd_ff == IDX_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      wr_nx = (wr_ff == IDX_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (wr_ff >= rd_ff) begin
         held = {1'b0, wr_ff} - {1'b0, rd_ff};
      end else begin
         held = {1'b0, wr_ff} + (IDX_W + 1)'(FIFO_DEPTH) - {1'b0, rd_ff};
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      tx_in     = tx_ff;
      rx_in     = rx_ff;
      drive_in  = drive_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      mem_we    = 1'b0;
      s1_mem_in = 1'b0;
      s1_in     = '0;
      cnt_nx    = cnt_ff + 5'd1;
      s1_in.queue_count = 4'(held);
      if (work) begin
         case (cmd_data.op)
            swbt_pkg::OP_TICK: begin
               if (mode_ff != LINK_IDLE) begin
                  cnt_in = cnt_nx;
                  if (mode_ff == LINK_RECV) begin
                     if (cnt_nx[0] && cnt_nx > 5'd2 && cnt_nx <= swbt_pkg::LAST_SAMPLE) begin
                        // sample into bit 0, shift up except on the last data bit
                        if (cnt_nx < swbt_pkg::LAST_SAMPLE) begin
                           rx_in = {rx_ff[6:1], cmd_data.line_in, 1'b0};
                        end else begin
                           rx_in = {rx_ff[7:1], cmd_data.line_in};
                        end
                     end else if (cnt_nx >= swbt_pkg::FRAME_END) begin
                        if (rx_ff != null_ff && wr_nx != rd_ff) begin
                           mem_we = 1'b1;
                           wr_in  = wr_nx;
                        end
                        mode_in = LINK_IDLE;
                     end
                  end else begin
                     if (cnt_nx >= swbt_pkg::FRAME_END) begin
                        drive_in = 1'b1;
                        mode_in  = LINK_IDLE;
                     end else if (!cnt_nx[0]) begin
                        drive_in = tx_ff[7];
                        tx_in    = {tx_ff[6:0], 1'b0};
                     end
                  end
               end
            end
            swbt_pkg::OP_FALL: begin
               if (mode_ff == LINK_IDLE) begin
                  mode_in = LINK_RECV;
                  cnt_in  = 5'd0;
                  rx_in   = 8'd0;
               end
            end
            swbt_pkg::OP_SEND: begin
               if (mode_ff == LINK_IDLE) begin
                  mode_in  = LINK_SEND;
                  cnt_in   = 5'd0;
                  tx_in    = cmd_data.send_byte;
                  drive_in = 1'b0;
                  s1_in.send_accepted = 1'b1;
               end
            end
            swbt_pkg::OP_POP: begin
               if (rd_ff != wr_ff) begin
                  // byte comes from the store read register one stage later
                  s1_mem_in       = 1'b1;
                  rd_in           = rd_nx;
                  s1_in.pop_valid = 1'b1;
               end else begin
                  s1_in.popped_byte = null_ff;
               end
            end
            swbt_pkg::OP_CLEAR: begin
               rd_in = '0;
               wr_in = '0;
            end
            default: begin
            end
         endcase
      end
      s1_in.line_out = drive_in;
      s1_in.busy_res = (mode_in != LINK_IDLE);
   end

   always_comb begin
      rsp_in = s1_ff;
      if (s1_mem_ff) begin
         rsp_in.popped_byte = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= LINK_IDLE;
         cnt_ff       <= 5'd0;
         tx_ff        <= 8'd0;
         rx_ff        <= 8'd0;
         drive_ff     <= 1'b1;
         rd_ff        <= '0;
         wr_ff        <= '0;
         null_ff      <= 8'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         tx_ff    <= tx_in;
         rx_ff    <= rx_in;
         drive_ff <= drive_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         if (csr_wr_en) begin
            null_ff <= csr_wr_data;
         end
         if (s1_load) begin
            s1_valid_ff <= cmd_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff     <= s1_in;
         s1_mem_ff <= s1_mem_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ff] <= rx_ff;
      end
      if (work && s1_mem_in) begin
         rd_data_ff <= mem[rd_ff];
      end
   end

   `SWBT_ASSERT_RST(a_idle_released, clock, reset, (mode_ff == LINK_IDLE) |-> drive_ff)
   `SWBT_ASSERT_RST(a_frame_bound, clock, reset,
                    (mode_ff != LINK_IDLE) |-> (cnt_ff <= swbt_pkg::LAST_SAMPLE))
   `SWBT_ASSERT_RST(a_pop_nonempty, clock, reset,
                    (s1_valid_ff && s1_ff.pop_valid) |-> (s1_ff.queue_count != 4'd0 || IDX_W >= 4))
   `SWBT_ASSERT_RST(a_s1_hold, clock, reset,
                    (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)

endmodule

// ===== hw/rtl/single_wire_byte_transceiver.sv =====
// Single-wire byte transceiver: one request beat on req_ per event (half-bit tick, bus falling
// edge, send, pop, clear) yields exactly one response beat on rsp_, in order. A frame is a low
// start bit and 8 data bits MSB first; received non-null bytes go into a ring store of
// FIFO_DEPTH bytes that holds at most FIFO_DEPTH-1. Throughput is one beat per clock while rsp_stall
// does not hold the output: a two-entry command queue sits between the decode front and the link
// engine, which retires one command per cycle unless the response stage is stalled. When nothing
// stalls, a req_ beat passes through the command queue, the result stage, with the store read
// register running beside it, and the response register that drives rsp_. csr_ writes the null
// byte and is to be written only while the block is idle.
module single_wire_byte_transceiver #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swbt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swbt_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   logic              cmd_valid;
   logic              cmd_take;
   swbt_pkg::cmd_type cmd_data;

   swbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data)
   );

   swbt_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take),
      .cmd_data    (cmd_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== bench/tb_single_wire_byte_transceiver.sv =====
`timescale 1ns / 1ps

module tb_single_wire_byte_transceiver;

   localparam int         DEPTH        = 16;
   localparam logic [2:0] ACT_RESERVED = 3'd7;
   localparam int         IDLE_PCT     = 38;

   typedef enum logic [1:0] {
      LINK_IDLE,
      LINK_RECV,
      LINK_SEND
   } link_state_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   swbt_pkg::req_type req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   swbt_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [7:0]        csr_wr_data = 8'h00;

   single_wire_byte_transceiver #(
      .FIFO_DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // link and fifo mirror
   link_state_type link_state = LINK_IDLE;
   logic [4:0]     half_count = '0;
   logic [7:0]     tx_shift   = '0;
   logic [7:0]     rx_shift   = '0;
   logic           bus_drive  = 1'b1;
   logic [7:0]     msg_store [DEPTH];
   logic [3:0]     rd_ptr     = '0;
   logic [3:0]     wr_ptr     = '0;
   logic [7:0]     null_value = 8'h00;

   swbt_pkg::req_type pending_req [$];
   swbt_pkg::rsp_type expected_rsp [$];
   swbt_pkg::rsp_type want_rsp;
   bit      steady       = 1'b0;
   int      mismatches   = 0;
   int      events_done  = 0;
   int      queued_items = 0;
   int      bytes_queued = 0;
   int      bytes_dropped = 0;
   int      sends_started = 0;
   int      pops_hit     = 0;
   int      clears_seen  = 0;

   function automatic swbt_pkg::rsp_type advance_link(input swbt_pkg::req_type r);
      swbt_pkg::rsp_type o;
      logic [3:0]        nxt;
      o = '0;
      o.queue_count = wr_ptr - rd_ptr;
      case (r.action)
         swbt_pkg::ACT_TICK: begin
            if (link_state != LINK_IDLE) begin
               half_count = half_count + 5'd1;
               if (link_state == LINK_RECV) begin
                  if (half_count[0] && half_count > 5'd2 &&
                      half_count <= swbt_pkg::LAST_SAMPLE) begin
                     rx_shift[0] = r.line_in;
                     if (half_count < swbt_pkg::LAST_SAMPLE) rx_shift = rx_shift << 1;
                  end else if (half_count >= swbt_pkg::FRAME_END) begin
                     nxt = wr_ptr + 4'd1;
                     if (rx_shift != null_value && nxt != rd_ptr) begin
                        msg_store[wr_ptr] = rx_shift;
                        wr_ptr = nxt;
                        bytes_queued++;
                     end else begin
                        bytes_dropped++;
                     end
                     link_state = LINK_IDLE;
                  end
               end else begin
                  if (half_count >= swbt_pkg::FRAME_END) begin
                     bus_drive = 1'b1;
                     link_state = LINK_IDLE;
                  end else if (!half_count[0]) begin
                     bus_drive = tx_shift[7];
                     tx_shift = tx_shift << 1;
                  end
               end
            end
         end
         swbt_pkg::ACT_FALL: begin
            if (link_state == LINK_IDLE) begin
               link_state = LINK_RECV;
               half_count = '0;
               rx_shift = '0;
            end
         end
         swbt_pkg::ACT_SEND: begin
            if (link_state == LINK_IDLE) begin
               link_state = LINK_SEND;
               half_count = '0;
               tx_shift = r.send_byte;
               bus_drive = 1'b0;
               o.send_accepted = 1'b1;
               sends_started++;
            end
         end
         swbt_pkg::ACT_POP: begin
            if (rd_ptr != wr_ptr) begin
               o.popped_byte = msg_store[rd_ptr];
               o.pop_valid = 1'b1;
               rd_ptr = rd_ptr + 4'd1;
               pops_hit++;
            end else begin
               o.popped_byte = null_value;
            end
         end
         swbt_pkg::ACT_CLEAR: begin
            rd_ptr = '0;
            wr_ptr = '0;
            clears_seen++;
         end
         default: ;
      endcase
      o.line_out = bus_drive;
      o.busy_res = (link_state != LINK_IDLE);
      return o;
   endfunction

   function automatic int field_bad(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // driver: a stalled beat holds, otherwise load the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(advance_link(req_data));
            events_done++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_req.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data <= pending_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response beat with nothing outstanding");
               mismatches++;
            end else begin
               want_rsp = expected_rsp.pop_front();
               mismatches += field_bad("line_out", 8'(want_rsp.line_out),
                                       8'(rsp_data.line_out));
               mismatches += field_bad("popped_byte", want_rsp.popped_byte,
                                       rsp_data.popped_byte);
               mismatches += field_bad("pop_valid", 8'(want_rsp.pop_valid),
                                       8'(rsp_data.pop_valid));
               mismatches += field_bad("queue_count", 8'(want_rsp.queue_count),
                                       8'(rsp_data.queue_count));
               mismatches += field_bad("busy_res", 8'(want_rsp.busy_res),
                                       8'(rsp_data.busy_res));
               mismatches += field_bad("send_accepted", 8'(want_rsp.send_accepted),
                                       8'(rsp_data.send_accepted));
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic push_item(input logic [2:0] action, input logic line,
                            input logic [7:0] data);
      swbt_pkg::req_type r;
      r.action = action;
      r.line_in = line;
      r.send_byte = data;
      pending_req.push_back(r);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0:       return null_value;
         1:       return 8'h00;
         2:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // software accesses landing in the middle of a frame
   task automatic maybe_fifo_access(input int pct);
      if ($urandom_range(99) < pct) begin
         push_item(($urandom_range(4) == 0) ? swbt_pkg::ACT_CLEAR : swbt_pkg::ACT_POP,
                   1'($urandom_range(1)), 8'($urandom_range(255)));
         queued_items++;
      end
   endtask

   task automatic queue_rx_ticks(input logic [7:0] b, input int mix_pct);
      int   t;
      logic lvl;
      for (t = 1; t <= 18; t++) begin
         maybe_fifo_access(mix_pct);
         if (t <= 2) lvl = 1'b0;
         else lvl = b[7 - (t - 3) / 2];
         // even ticks are never sampled
         if (t % 2 == 0 && $urandom_range(9) == 0) lvl = !lvl;
         push_item(swbt_pkg::ACT_TICK, lvl, 8'($urandom_range(255)));
      end
      queued_items += 18;
   endtask

   task automatic queue_tx_frame(input logic [7:0] b, input int mix_pct);
      int t;
      push_item(swbt_pkg::ACT_SEND, 1'($urandom_range(1)), b);
      for (t = 1; t <= 18; t++) begin
         maybe_fifo_access(mix_pct);
         push_item(swbt_pkg::ACT_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end
      queued_items += 19;
   endtask

   task automatic queue_random_phase(input int target, input int pop_pct);
      int r;
      int k;
      int start;
      start = queued_items;
      while (queued_items - start < target) begin
         r = $urandom_range(99);
         if (r < 45) begin
            push_item(swbt_pkg::ACT_FALL, 1'b0, 8'($urandom_range(255)));
            queued_items++;
            queue_rx_ticks(pick_byte(), pop_pct / 2);
         end else if (r < 62) begin
            queue_tx_frame(pick_byte(), pop_pct / 2);
         end else if (r < 62 + pop_pct) begin
            k = $urandom_range(1, 3);
            repeat (k) push_item(swbt_pkg::ACT_POP, 1'($urandom_range(1)),
                                 8'($urandom_range(255)));
            queued_items += k;
         end else if (r < 64 + pop_pct) begin
            push_item(swbt_pkg::ACT_CLEAR, 1'($urandom_range(1)), 8'($urandom_range(255)));
            queued_items++;
         end else if (r < 90) begin
            // truncated frame, later beats finish it or collide with it
            k = $urandom_range(17);
            push_item($urandom_range(1) ? swbt_pkg::ACT_FALL : swbt_pkg::ACT_SEND,
                      1'($urandom_range(1)), pick_byte());
            repeat (k) push_item(swbt_pkg::ACT_TICK, 1'($urandom_range(1)),
                                 8'($urandom_range(255)));
            queued_items += k + 1;
         end else begin
            k = $urandom_range(1, 4);
            repeat (k) push_item(3'($urandom_range(ACT_RESERVED)), 1'($urandom_range(1)),
                                 8'($urandom_range(255)));
            queued_items += k;
         end
      end
   endtask

   task automatic write_null(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      null_value = v;
   endtask

   task automatic wait_all_done();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_null(8'h00);

      // directed: empty fifo access, idle tick, unused code, collisions, one frame
      push_item(swbt_pkg::ACT_POP, 1'b1, 8'h00);
      push_item(swbt_pkg::ACT_CLEAR, 1'b0, 8'hFF);
      push_item(swbt_pkg::ACT_TICK, 1'b1, 8'h00);
      push_item(ACT_RESERVED, 1'b1, 8'hFF);
      push_item(swbt_pkg::ACT_FALL, 1'b0, 8'h00);
      push_item(swbt_pkg::ACT_FALL, 1'b0, 8'h00);
      push_item(swbt_pkg::ACT_SEND, 1'b1, 8'hFF);
      queue_rx_ticks(8'h81, 0);
      push_item(swbt_pkg::ACT_POP, 1'b0, 8'h00);
      push_item(swbt_pkg::ACT_POP, 1'b0, 8'h00);
      wait_all_done();

      queue_random_phase(400, 20);
      wait_all_done();

      write_null(8'hFF);
      steady = 1'b1;
      queue_random_phase(400, 20);
      wait_all_done();
      steady = 1'b0;

      // few pops so the store runs full
      write_null(8'($urandom_range(1, 254)));
      queue_random_phase(450, 3);
      wait_all_done();

      write_null(8'h80);
      queue_random_phase(450, 25);
      wait_all_done();

      $display("%0d events checked across four null-byte settings: %0d bytes stored, %0d dropped",
               events_done, bytes_queued, bytes_dropped);
      $display("%0d transmissions started, %0d pops returned data, %0d clears",
               sends_started, pops_hit, clears_seen);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("single_wire_byte_transceiver test passed");
      end else begin
         $display("single_wire_byte_transceiver test failed");
      end
      $finish;
   end

   initial begin
      #(12 * 400_000);
      $display("timeout with %0d beats outstanding", expected_rsp.size());
      $display("single_wire_byte_transceiver test failed");
      $finish;
   end

endmodule
